FILE: design/ocsw_pkg.sv
// Shared constants, register codes and rounding helpers for the opponent-color weight core.
`timescale 1ns / 1ps

package ocsw_pkg;

  // register indexes on the configuration port (byte address = 4 * index)
  localparam logic [2:0] REG_REF_RED     = 3'd0;
  localparam logic [2:0] REG_REF_GREEN   = 3'd1;
  localparam logic [2:0] REG_REF_BLUE    = 3'd2;
  localparam logic [2:0] REG_EXP_OFFSET  = 3'd3;
  localparam logic [2:0] REG_SENSITIVITY = 3'd4;
  localparam logic [2:0] REG_FACTOR_GAIN = 3'd5;

  localparam int ADDR_W = 5;

  // reset values
  localparam logic [7:0]         RST_REF_RED     = 8'd167;
  localparam logic [7:0]         RST_REF_GREEN   = 8'd128;
  localparam logic [7:0]         RST_REF_BLUE    = 8'd116;
  localparam logic signed [12:0] RST_EXP_OFFSET  = 13'sd512;
  localparam logic [15:0]        RST_SENSITIVITY = 16'd12800;
  localparam logic [15:0]        RST_FACTOR_GAIN = 16'd9362;

  localparam int WEIGHT_FRAC_BITS_DEF = 14;

  // Q.16 constants
  localparam logic signed [17:0] INV_SQRT2_Q16 = 18'sd46341;
  localparam logic signed [17:0] INV_SQRT6_Q16 = 18'sd26755;
  localparam logic signed [17:0] INV_SQRT3_Q16 = 18'sd37837;
  localparam logic signed [17:0] LOG2E_Q16     = 18'sd94548;

  // 2^f cubic coefficients, Q.16
  localparam logic [15:0] EXP_C1  = 16'd45600;
  localparam logic [15:0] EXP_C2  = 16'd14752;
  localparam logic [15:0] EXP_C3  = 16'd5184;
  localparam logic [16:0] EXP_ONE = 17'd65536;

  // Shift right by 16, rounding half away from zero.
  function automatic logic signed [17:0] rnd16(input logic signed [34:0] v);
    logic [34:0] mag;
    logic [34:0] r;
    begin
      mag = v[34] ? 35'(-v) : 35'(v);
      r   = (mag + 35'd32768) >> 16;
      rnd16 = v[34] ? -$signed(r[17:0]) : $signed(r[17:0]);
    end
  endfunction

  // Shift right by 8, rounding half away from zero.
  function automatic logic signed [29:0] rnd8(input logic signed [37:0] v);
    logic [37:0] mag;
    logic [37:0] r;
    begin
      mag = v[37] ? 38'(-v) : 38'(v);
      r   = (mag + 38'd128) >> 8;
      rnd8 = v[37] ? -$signed(r[29:0]) : $signed(r[29:0]);
    end
  endfunction

endpackage

FILE: design/ocsw_exp.sv
// Exponent back end: exp(A) as 2^(A*log2e), gain cube, final scaling and output register.
`timescale 1ns / 1ps

module ocsw_exp #(
  parameter int WEIGHT_FRAC_BITS = ocsw_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [20:0] a,
  input  logic [15:0]        factor_gain,
  output logic               out_valid,
  output logic [15:0]        weight
);

  localparam int SHIFT_BIAS = 32 - WEIGHT_FRAC_BITS;

  logic               v1, v2, v3, v4, v5, v6;
  logic signed [37:0] ta;
  logic signed [13:0] n2, n3, n4, n5, n6;
  logic [15:0]        f2, f3, f4;
  logic [14:0]        m1;
  logic [16:0]        m2;
  logic [16:0]        m3;
  logic [32:0]        prod;
  logic [15:0]        g2, g3;

  logic signed [29:0] t_rnd;
  logic [31:0]        prod1;
  logic [32:0]        prod2;
  logic [32:0]        prod3;
  logic [32:0]        gg2;
  logic [32:0]        gg3;
  logic signed [14:0] sh;
  logic [14:0]        k;
  logic [5:0]         k6;
  logic [48:0]        up;
  logic [34:0]        down;
  logic [15:0]        weight_next;

  // gain cube follows the register through the g2 and g3 registers
  always_comb begin
    gg2 = 33'(factor_gain) * 33'(factor_gain) + 33'd32768;
    gg3 = 33'(g2) * 33'(factor_gain) + 33'd32768;
  end

  always_ff @(posedge clk) begin
    g2 <= gg2[31:16];
    g3 <= gg3[31:16];
  end

  always_comb begin
    t_rnd = ocsw_pkg::rnd8(ta);
    prod1 = 32'(ocsw_pkg::EXP_C3) * 32'(f2);
    prod2 = 33'(m1) * 33'(f3);
    prod3 = 33'(m2) * 33'(f4);
  end

  // final scaling by 2^n with saturation and rounding
  always_comb begin
    sh   = 15'(n6) - 15'(SHIFT_BIAS);
    k    = 15'(-sh);
    k6   = k[5:0];
    up   = 49'(prod) << sh[3:0];
    down = (35'(prod) + (35'd1 << (k6 - 6'd1))) >> k6;
    if (prod == 33'd0) begin
      weight_next = 16'd0;
    end else if (!sh[14]) begin
      if (sh >= 15'sd16 || up[48:16] != 33'd0) begin
        weight_next = 16'hFFFF;
      end else begin
        weight_next = up[15:0];
      end
    end else if (k > 15'd34) begin
      weight_next = 16'd0;
    end else if (down[34:16] != 19'd0) begin
      weight_next = 16'hFFFF;
    end else begin
      weight_next = down[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ta     <= 38'(a) * 38'(ocsw_pkg::LOG2E_Q16);
      n2     <= t_rnd[29:16];
      f2     <= t_rnd[15:0];
      m1     <= 15'(32'(ocsw_pkg::EXP_C2) + (prod1 >> 16));
      n3     <= n2;
      f3     <= f2;
      m2     <= 17'(33'(ocsw_pkg::EXP_C1) + (prod2 >> 16));
      n4     <= n3;
      f4     <= f3;
      m3     <= 17'(33'(ocsw_pkg::EXP_ONE) + (prod3 >> 16));
      n5     <= n4;
      prod   <= 33'(g3) * 33'(m3);
      n6     <= n5;
      weight <= weight_next;
    end
  end

  a_zero_product: assert property (@(posedge clk) disable iff (rst)
    (en && v6 && prod == 33'd0) |=> (out_valid && weight == 16'd0))
    else $error("zero product did not give a zero weight");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable({v1, v2, v3, v4, v5, v6, out_valid}))
    else $error("exponent pipeline moved during a stall");

endmodule

FILE: design/opponent_color_similarity_weight_core.sv
// Top level: configuration registers, opponent-color front end and stream handshake.
`timescale 1ns / 1ps

// Opponent-color skin similarity weight. Takes one RGB pixel per clock on
// s_axis and returns one 16-bit weight (unsigned, WEIGHT_FRAC_BITS fraction
// bits, saturating at 0xFFFF) per pixel on m_axis, in order. An accepted
// pixel reaches m_axis_tvalid through six stages for the opponent transform,
// difference, square and sensitivity product, then seven for the exponential,
// gain cube and final scaling, at most one multiplier deep per stage.
// Throughput is one pixel per clock; the whole pipeline holds while
// m_axis_tvalid is high and m_axis_tready is low. Registers are to be written
// over the APB-style port while the stream is idle, which the block does not
// enforce; a new factor_gain reaches the gain cube via the g2 and g3 registers.
module opponent_color_similarity_weight_core #(
  parameter int WEIGHT_FRAC_BITS = ocsw_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ocsw_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // pixel stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  // weight stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata   // weight[15:0]
);

  logic [7:0]         ref_red, ref_green, ref_blue;
  logic signed [12:0] exp_offset;
  logic [15:0]        sensitivity, factor_gain;

  logic               adv;
  logic [2:0]         reg_idx;
  logic               v1, v2, v3, v4, v5, v6;

  logic [15:0]        rn, gn, bn;
  logic [14:0]        rr, rg, rb;
  logic signed [16:0] ps0, rs0;
  logic signed [17:0] ps1, ps2, rs1, rs2;
  logic signed [34:0] pp0, pp1, pp2, rp0, rp1, rp2;
  logic signed [17:0] d0, d1, d2;
  logic signed [17:0] d0_next, d1_next, d2_next;
  logic [16:0]        ad0, ad1, ad2;
  logic [33:0]        dd0_full, dd1_full, dd2_full;
  logic [31:0]        dd0, dd1, dd2;
  logic [17:0]        sq0, sq1, sq2;
  logic [33:0]        sp0, sp1, sp2;
  logic [17:0]        p0, p1, p2;
  logic signed [20:0] off21;
  logic signed [20:0] a, a_next;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_red     <= ocsw_pkg::RST_REF_RED;
      ref_green   <= ocsw_pkg::RST_REF_GREEN;
      ref_blue    <= ocsw_pkg::RST_REF_BLUE;
      exp_offset  <= ocsw_pkg::RST_EXP_OFFSET;
      sensitivity <= ocsw_pkg::RST_SENSITIVITY;
      factor_gain <= ocsw_pkg::RST_FACTOR_GAIN;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        ocsw_pkg::REG_REF_RED:     ref_red     <= pwdata[7:0];
        ocsw_pkg::REG_REF_GREEN:   ref_green   <= pwdata[7:0];
        ocsw_pkg::REG_REF_BLUE:    ref_blue    <= pwdata[7:0];
        ocsw_pkg::REG_EXP_OFFSET:  exp_offset  <= $signed(pwdata[12:0]);
        ocsw_pkg::REG_SENSITIVITY: sensitivity <= pwdata[15:0];
        ocsw_pkg::REG_FACTOR_GAIN: factor_gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ocsw_pkg::REG_REF_RED:     prdata = 32'(ref_red);
      ocsw_pkg::REG_REF_GREEN:   prdata = 32'(ref_green);
      ocsw_pkg::REG_REF_BLUE:    prdata = 32'(ref_blue);
      ocsw_pkg::REG_EXP_OFFSET:  prdata = 32'(unsigned'(exp_offset));
      ocsw_pkg::REG_SENSITIVITY: prdata = 32'(sensitivity);
      ocsw_pkg::REG_FACTOR_GAIN: prdata = 32'(factor_gain);
      default:                   prdata = 32'd0;
    endcase
  end

  // advance everything unless a finished weight is waiting
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // p/255 in Q.15 rounds to 128*p + ceil(p/2); the reference is r/256
  always_comb begin
    rn = 16'({s_axis_tdata[7:0], 7'd0}) + 16'((9'(s_axis_tdata[7:0]) + 9'd1) >> 1);
    gn = 16'({s_axis_tdata[15:8], 7'd0}) + 16'((9'(s_axis_tdata[15:8]) + 9'd1) >> 1);
    bn = 16'({s_axis_tdata[23:16], 7'd0}) + 16'((9'(s_axis_tdata[23:16]) + 9'd1) >> 1);
    rr = {ref_red, 7'd0};
    rg = {ref_green, 7'd0};
    rb = {ref_blue, 7'd0};
  end

  always_comb begin
    d0_next = ocsw_pkg::rnd16(pp0) - ocsw_pkg::rnd16(rp0);
    d1_next = ocsw_pkg::rnd16(pp1) - ocsw_pkg::rnd16(rp1);
    d2_next = ocsw_pkg::rnd16(pp2) - ocsw_pkg::rnd16(rp2);
    ad0 = d0[17] ? 17'(-d0) : 17'(d0);
    ad1 = d1[17] ? 17'(-d1) : 17'(d1);
    ad2 = d2[17] ? 17'(-d2) : 17'(d2);
    dd0_full = 34'(ad0) * 34'(ad0);
    dd1_full = 34'(ad1) * 34'(ad1);
    dd2_full = 34'(ad2) * 34'(ad2);
    sq0 = 18'((33'(dd0) + 33'd8192) >> 14);
    sq1 = 18'((33'(dd1) + 33'd8192) >> 14);
    sq2 = 18'((33'(dd2) + 33'd8192) >> 14);
    p0  = 18'((35'(sp0) + 35'd32768) >> 16);
    p1  = 18'((35'(sp1) + 35'd32768) >> 16);
    p2  = 18'((35'(sp2) + 35'd32768) >> 16);
    off21  = 21'(exp_offset);
    a_next = off21 + off21 + off21 - $signed({3'd0, p0}) - $signed({3'd0, p1})
           - $signed({3'd0, p2});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // opponent sums
      ps0 <= $signed({1'b0, rn}) - $signed({1'b0, gn});
      ps1 <= $signed({2'd0, rn}) + $signed({2'd0, gn}) - $signed({1'b0, bn, 1'b0});
      ps2 <= $signed({2'd0, rn}) + $signed({2'd0, gn}) + $signed({2'd0, bn});
      rs0 <= $signed({2'd0, rr}) - $signed({2'd0, rg});
      rs1 <= $signed({3'd0, rr}) + $signed({3'd0, rg}) - $signed({2'd0, rb, 1'b0});
      rs2 <= $signed({3'd0, rr}) + $signed({3'd0, rg}) + $signed({3'd0, rb});
      // scale by 1/sqrt2, 1/sqrt6, 1/sqrt3
      pp0 <= 35'(ps0) * 35'(ocsw_pkg::INV_SQRT2_Q16);
      pp1 <= 35'(ps1) * 35'(ocsw_pkg::INV_SQRT6_Q16);
      pp2 <= 35'(ps2) * 35'(ocsw_pkg::INV_SQRT3_Q16);
      rp0 <= 35'(rs0) * 35'(ocsw_pkg::INV_SQRT2_Q16);
      rp1 <= 35'(rs1) * 35'(ocsw_pkg::INV_SQRT6_Q16);
      rp2 <= 35'(rs2) * 35'(ocsw_pkg::INV_SQRT3_Q16);
      d0  <= d0_next;
      d1  <= d1_next;
      d2  <= d2_next;
      dd0 <= dd0_full[31:0];
      dd1 <= dd1_full[31:0];
      dd2 <= dd2_full[31:0];
      sp0 <= 34'(sensitivity) * 34'(sq0);
      sp1 <= 34'(sensitivity) * 34'(sq1);
      sp2 <= 34'(sensitivity) * 34'(sq2);
      a   <= a_next;
    end
  end

  ocsw_exp #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_exp (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (v6),
    .a           (a),
    .factor_gain (factor_gain),
    .out_valid   (m_axis_tvalid),
    .weight      (m_axis_tdata)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> v1)
    else $error("accepted pixel did not enter the pipeline");

  a_ready_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting weight");

  a_front_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({v1, v2, v3, v4, v5, v6}))
    else $error("front pipeline moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("weight valid right after reset");

endmodule
